FILE: hw/rtl/fcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_pkg
// Shared types and constants of the framed command parser: character codes,
// status codes, command identifiers and the result bundle.
// ----------------------------------------------------------------------------
package fcp_pkg;

    // Characters of the frame syntax
    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_BLANK = 8'h49;  // 'I'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_FIVE  = 8'h35;  // '5'
    localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Most LED pattern digits taken per frame (1 to 3)
    localparam int unsigned LED_DIGITS = 2;

    // Value limits
    localparam logic [3:0] DIGIT_BLANK = 4'd10;
    localparam logic [2:0] FIELD_MAX   = 3'd7;
    localparam logic [6:0] LED_MAX     = 7'd127;

    // Command identifiers
    localparam logic [2:0] CMD_MEMORY   = 3'd3;
    localparam logic [2:0] CMD_LED      = 3'd6;
    localparam logic [2:0] CMD_MOTOR    = 3'd7;
    localparam logic [2:0] CMD_MODE_MAX = 3'd4;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COMM  = 2'd1,
        ST_NOCMD = 2'd2
    } t_status;

    // One result transaction
    typedef struct packed {
        t_status    status;
        logic       frame_done;
        logic [2:0] active_mode;
        logic [3:0] display_digit;
        logic [2:0] display_level;
        logic [6:0] led_pattern;
        logic       led_update;
        logic       motor_on;
        logic       motor_update;
    } t_result;

endpackage

FILE: hw/rtl/fcp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_in_reg
// Input register of the parser: captures one received character per
// transaction and holds it until the parse stage takes it.
// ----------------------------------------------------------------------------
module fcp_in_reg
    import fcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_char
);

    logic       r_valid;
    logic [7:0] r_char;
    logic       accept;

    // Stall only while a held character is not being taken
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    // Capture a new transaction, drop the old one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

FILE: hw/rtl/fcp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_parser
// Frame parser state machine: one character per load, updates the parse
// state and the command registers and registers status and update pulses.
// ----------------------------------------------------------------------------
module fcp_parser
    import fcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [7:0] i_char,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_CMD   = 3'd1,
        PH_MEM   = 3'd2,
        PH_LED   = 3'd3,
        PH_MOTOR = 3'd4,
        PH_END   = 3'd5
    } t_phase;

    // Field positions inside a memory frame
    localparam logic [2:0] FLD_DIGIT = 3'd0;
    localparam logic [2:0] FLD_SEP   = 3'd1;
    localparam logic [2:0] FLD_LEVEL = 3'd2;
    localparam logic [2:0] FLD_CLOSE = 3'd3;
    localparam logic [2:0] LED_LIMIT = 3'(LED_DIGITS);

    t_phase     r_phase, n_phase;
    logic [2:0] r_index, n_index;
    logic [2:0] r_cmd, n_cmd;
    logic [3:0] r_digit, n_digit;
    logic [2:0] r_level, n_level;
    logic [6:0] r_accum, n_accum;
    logic [6:0] r_led, n_led;
    logic       r_motor, n_motor;
    logic [2:0] r_mode, n_mode;
    t_status    r_status, n_status;
    logic       r_done, n_done;
    logic       r_led_up, n_led_up;
    logic       r_mot_up, n_mot_up;

    logic       is_digit;
    logic       bump;
    logic [10:0] led_sum;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign led_sum  = 11'(r_accum) * 11'd10 + 11'(i_char[3:0]);

    // Next state of the parse for the current character
    always_comb begin
        n_phase  = r_phase;
        n_index  = r_index;
        n_cmd    = r_cmd;
        n_digit  = r_digit;
        n_level  = r_level;
        n_accum  = r_accum;
        n_led    = r_led;
        n_motor  = r_motor;
        n_mode   = r_mode;
        n_status = ST_OK;
        n_done   = 1'b0;
        n_led_up = 1'b0;
        n_mot_up = 1'b0;
        bump     = 1'b0;

        case (r_phase)
            PH_CMD: begin
                if ((i_char >= CH_ZERO) && (i_char <= CH_SEVEN)) begin
                    n_cmd = i_char[2:0];
                end else if (i_char == CH_COMMA) begin
                    if (r_cmd == CMD_MEMORY) begin
                        n_phase = PH_MEM;
                    end else if (r_cmd == CMD_LED) begin
                        n_phase = PH_LED;
                    end else if (r_cmd == CMD_MOTOR) begin
                        n_phase = PH_MOTOR;
                    end else begin
                        n_phase = PH_END;
                    end
                end else begin
                    n_phase  = PH_START;
                    n_status = ST_NOCMD;
                end
            end
            PH_MEM: begin
                bump = 1'b1;
                if (r_index == FLD_DIGIT) begin
                    if (is_digit) begin
                        n_digit = i_char[3:0];
                    end else if (i_char == CH_BLANK) begin
                        n_digit = DIGIT_BLANK;
                    end
                end else if (r_index == FLD_LEVEL) begin
                    if ((i_char >= CH_ONE) && (i_char <= CH_FIVE)) begin
                        n_level = i_char[2:0];
                    end
                end else if (r_index == FLD_CLOSE) begin
                    if (i_char == CH_COMMA) begin
                        n_phase = PH_END;
                    end
                end else if (r_index == FLD_SEP) begin
                    if (i_char != CH_COMMA) begin
                        n_phase = PH_START;
                    end
                end
            end
            PH_LED: begin
                if (is_digit) begin
                    // Ignore digits beyond the LED_DIGITS limit
                    if (r_index < LED_LIMIT) begin
                        n_accum = (led_sum > 11'(LED_MAX)) ? LED_MAX : led_sum[6:0];
                        bump    = 1'b1;
                    end
                end else if (i_char == CH_COMMA) begin
                    n_led    = r_accum;
                    n_led_up = 1'b1;
                    n_phase  = PH_END;
                end else begin
                    n_phase = PH_START;
                end
            end
            PH_MOTOR: begin
                if ((i_char == CH_ZERO) || (i_char == CH_ONE)) begin
                    n_motor  = i_char[0];
                    n_mot_up = 1'b1;
                end else if (i_char == CH_COMMA) begin
                    n_phase = PH_END;
                end else begin
                    n_phase  = PH_START;
                    n_status = ST_COMM;
                end
            end
            PH_END: begin
                if (i_char == CH_CLOSE) begin
                    n_done = 1'b1;
                    if (r_cmd <= CMD_MODE_MAX) begin
                        n_mode = r_cmd;
                    end
                end else begin
                    n_status = ST_COMM;
                end
                n_phase = PH_START;
            end
            default: begin
                if (i_char == CH_OPEN) begin
                    n_phase = PH_CMD;
                    n_index = 3'd0;
                    n_accum = 7'd0;
                end else begin
                    n_phase  = PH_START;
                    n_status = ST_COMM;
                end
            end
        endcase

        // Saturate the field index
        if (bump && (r_index != FIELD_MAX)) begin
            n_index = r_index + 3'd1;
        end
    end

    // Hold parse state and registered result; advance on each load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_index  <= 3'd0;
            r_cmd    <= 3'd0;
            r_digit  <= DIGIT_BLANK;
            r_level  <= 3'd0;
            r_accum  <= 7'd0;
            r_led    <= 7'd0;
            r_motor  <= 1'b0;
            r_mode   <= 3'd0;
            r_status <= ST_OK;
            r_done   <= 1'b0;
            r_led_up <= 1'b0;
            r_mot_up <= 1'b0;
        end else if (i_load) begin
            r_phase  <= n_phase;
            r_index  <= n_index;
            r_cmd    <= n_cmd;
            r_digit  <= n_digit;
            r_level  <= n_level;
            r_accum  <= n_accum;
            r_led    <= n_led;
            r_motor  <= n_motor;
            r_mode   <= n_mode;
            r_status <= n_status;
            r_done   <= n_done;
            r_led_up <= n_led_up;
            r_mot_up <= n_mot_up;
        end
    end

    always_comb begin
        o_result.status        = r_status;
        o_result.frame_done    = r_done;
        o_result.active_mode   = r_mode;
        o_result.display_digit = r_digit;
        o_result.display_level = r_level;
        o_result.led_pattern   = r_led;
        o_result.led_update    = r_led_up;
        o_result.motor_on      = r_motor;
        o_result.motor_update  = r_mot_up;
    end

endmodule

FILE: hw/rtl/framed_command_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_parser_unit
// Parses received characters into <id,fields,> frames, one result per
// character, with status, mode, display, LED and motor outputs.
// ----------------------------------------------------------------------------
// Path: an accepted character is held in the input register, then parsed
//   into the result register; an output stall can hold it in between.
// Throughput: 1 character per cycle while the output is not stalled; the parse state updates on each load.
// Reset: synchronous, active low; empties both registers, parser waits for
//   '<', display digit reads blank, all other outputs read zero.
module framed_command_parser_unit
    import fcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic       o_frame_done,
    output logic [2:0] o_active_mode,
    output logic [3:0] o_display_digit,
    output logic [2:0] o_display_level,
    output logic [6:0] o_led_pattern,
    output logic       o_led_update,
    output logic       o_motor_on,
    output logic       o_motor_update
);

    logic       in_valid;
    logic [7:0] in_char;
    logic       advance;
    logic       r_out_valid;
    t_result    result;

    // Move a character into the parser when the result slot is free or being taken
    assign advance = in_valid && (!r_out_valid || !i_out_stall);

    fcp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_char  (i_rx_char),
        .i_take  (advance),
        .o_valid (in_valid),
        .o_char  (in_char)
    );

    fcp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_char   (in_char),
        .o_result (result)
    );

    // Track the result transaction until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = result.status;
    assign o_frame_done    = result.frame_done;
    assign o_active_mode   = result.active_mode;
    assign o_display_digit = result.display_digit;
    assign o_display_level = result.display_level;
    assign o_led_pattern   = result.led_pattern;
    assign o_led_update    = result.led_update;
    assign o_motor_on      = result.motor_on;
    assign o_motor_update  = result.motor_update;

endmodule

FILE: hw/rtl/fcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcp_checker
// Port-level checks of the parser: persistent outputs change only with their
// update pulse, a frame close reports no error and a stalled result holds.
// ----------------------------------------------------------------------------
module fcp_checker
    import fcp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic       o_frame_done,
    input logic [2:0] o_active_mode,
    input logic [6:0] o_led_pattern,
    input logic       o_led_update,
    input logic       o_motor_on,
    input logic       o_motor_update
);

    // Mode changes only with a closed frame
    a_mode_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_active_mode) |-> (o_out_valid && o_frame_done))
        else $error("active mode changed without a frame close");

    // LED pattern changes only with its update pulse
    a_led_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_led_pattern) |-> (o_out_valid && o_led_update))
        else $error("LED pattern changed without an update pulse");

    // Motor state changes only with its update pulse
    a_motor_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_motor_on) |-> (o_out_valid && o_motor_update))
        else $error("motor state changed without an update pulse");

    // A closed frame reports ok status
    a_done_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_status == ST_OK))
        else $error("frame close reported with an error status");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_frame_done)))
        else $error("stalled result transaction changed");

endmodule

bind framed_command_parser_unit fcp_checker u_fcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_frame_done   (o_frame_done),
    .o_active_mode  (o_active_mode),
    .o_led_pattern  (o_led_pattern),
    .o_led_update   (o_led_update),
    .o_motor_on     (o_motor_on),
    .o_motor_update (o_motor_update)
);

FILE: verif/framed_command_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_parser_unit_tb
// Drives received characters into the parser, predicts each result from a
// behavioural copy of the frame parser and checks every result transaction
// field by field. A directed opening is followed by random frames, noise
// and broken frames, with random idling on both channels.
// ----------------------------------------------------------------------------
module framed_command_parser_unit_tb;
    import fcp_pkg::*;

    localparam int unsigned RANDOM_CHARS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned REPORT_MAX   = 10;

    typedef enum logic [2:0] {
        PH_START,
        PH_CMD,
        PH_MEM,
        PH_LED,
        PH_MOTOR,
        PH_END
    } t_phase;

    // Behavioural parser state and the queue of results still to arrive
    class frame_parse_tracker;
        t_phase      phase;
        logic [2:0]  field_idx;
        logic [2:0]  cmd_id;
        logic [3:0]  digit;
        logic [2:0]  level;
        logic [6:0]  led_acc;
        logic [6:0]  led;
        logic        motor;
        logic [2:0]  mode;
        t_result     pending_results[$];
        int unsigned errors;
        int unsigned mismatches;

        function new();
            phase      = PH_START;
            field_idx  = '0;
            cmd_id     = '0;
            digit      = DIGIT_BLANK;
            level      = '0;
            led_acc    = '0;
            led        = '0;
            motor      = 1'b0;
            mode       = '0;
            errors     = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

        // True when the memory frame must close with a comma to avoid locking up
        function bit needs_field_close();
            return phase == PH_MEM && field_idx == 3'd3;
        endfunction

        function void bump_field();
            if (field_idx < FIELD_MAX) begin
                field_idx = field_idx + 3'd1;
            end
        endfunction

        // Advance the parser by one accepted character and queue its result
        function void parse_char(logic [7:0] c);
            t_result r;
            int      acc;
            bit      is_dig;
            r = '0;
            r.status = ST_OK;
            is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
            case (phase)
                PH_CMD: begin
                    if (c >= CH_ZERO && c <= CH_SEVEN) begin
                        cmd_id = 3'(c - CH_ZERO);
                    end else if (c == CH_COMMA) begin
                        if (cmd_id == CMD_MEMORY) phase = PH_MEM;
                        else if (cmd_id == CMD_LED) phase = PH_LED;
                        else if (cmd_id == CMD_MOTOR) phase = PH_MOTOR;
                        else phase = PH_END;
                    end else begin
                        phase = PH_START;
                        r.status = ST_NOCMD;
                    end
                end
                PH_MEM: begin
                    case (field_idx)
                        3'd0: begin
                            if (is_dig) digit = 4'(c - CH_ZERO);
                            else if (c == CH_BLANK) digit = DIGIT_BLANK;
                        end
                        3'd1: begin
                            if (c != CH_COMMA) phase = PH_START;
                        end
                        3'd2: begin
                            if (c >= CH_ONE && c <= CH_FIVE) level = 3'(c - CH_ZERO);
                        end
                        3'd3: begin
                            if (c == CH_COMMA) phase = PH_END;
                        end
                        default: ;
                    endcase
                    bump_field();
                end
                PH_LED: begin
                    if (is_dig) begin
                        // take at most LED_DIGITS digits, saturate the value
                        if (field_idx < LED_DIGITS) begin
                            acc = int'(led_acc) * 10 + int'(c - CH_ZERO);
                            led_acc = (acc > int'(LED_MAX)) ? LED_MAX : 7'(acc);
                            bump_field();
                        end
                    end else if (c == CH_COMMA) begin
                        led = led_acc;
                        r.led_update = 1'b1;
                        phase = PH_END;
                    end else begin
                        phase = PH_START;
                    end
                end
                PH_MOTOR: begin
                    if (c == CH_ZERO || c == CH_ONE) begin
                        motor = c[0];
                        r.motor_update = 1'b1;
                    end else if (c == CH_COMMA) begin
                        phase = PH_END;
                    end else begin
                        phase = PH_START;
                        r.status = ST_COMM;
                    end
                end
                PH_END: begin
                    if (c == CH_CLOSE) begin
                        r.frame_done = 1'b1;
                        if (cmd_id <= CMD_MODE_MAX) mode = cmd_id;
                    end else begin
                        r.status = ST_COMM;
                    end
                    phase = PH_START;
                end
                default: begin
                    if (c == CH_OPEN) begin
                        phase = PH_CMD;
                        field_idx = '0;
                        led_acc = '0;
                    end else begin
                        phase = PH_START;
                        r.status = ST_COMM;
                    end
                end
            endcase
            r.active_mode   = mode;
            r.display_digit = digit;
            r.display_level = level;
            r.led_pattern   = led;
            r.motor_on      = motor;
            pending_results.push_back(r);
        endfunction

        // Compare one received result with the oldest expectation
        function void match_result(t_result got);
            t_result want;
            bit      bad;
            if (pending_results.size() == 0) begin
                errors++;
                if (mismatches < REPORT_MAX) begin
                    $display("ERROR: result with nothing expected: %h", got);
                end
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            bad = (got.status !== want.status) || (got.frame_done !== want.frame_done)
               || (got.active_mode !== want.active_mode)
               || (got.display_digit !== want.display_digit)
               || (got.display_level !== want.display_level)
               || (got.led_pattern !== want.led_pattern)
               || (got.led_update !== want.led_update)
               || (got.motor_on !== want.motor_on)
               || (got.motor_update !== want.motor_update);
            if (bad) begin
                errors++;
                if (mismatches < REPORT_MAX) begin
                    $display("ERROR: mismatch exp st=%0d done=%b mode=%0d dig=%0d lvl=%0d led=%0d ledup=%b mot=%b motup=%b",
                             want.status, want.frame_done, want.active_mode,
                             want.display_digit, want.display_level, want.led_pattern,
                             want.led_update, want.motor_on, want.motor_update);
                    $display("       got    st=%0d done=%b mode=%0d dig=%0d lvl=%0d led=%0d ledup=%b mot=%b motup=%b",
                             got.status, got.frame_done, got.active_mode,
                             got.display_digit, got.display_level, got.led_pattern,
                             got.led_update, got.motor_on, got.motor_update);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_char;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic        o_frame_done;
    logic [2:0]  o_active_mode;
    logic [3:0]  o_display_digit;
    logic [2:0]  o_display_level;
    logic [6:0]  o_led_pattern;
    logic        o_led_update;
    logic        o_motor_on;
    logic        o_motor_update;

    frame_parse_tracker tracker;
    logic [7:0]         directed_chars[$];
    logic [7:0]         frame_chars[$];
    int unsigned        random_sent;
    int unsigned        cycle_count;
    bit                 tx_quiet;
    bit                 rx_quiet;

    framed_command_parser_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_char       (i_rx_char),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_frame_done    (o_frame_done),
        .o_active_mode   (o_active_mode),
        .o_display_digit (o_display_digit),
        .o_display_level (o_display_level),
        .o_led_pattern   (o_led_pattern),
        .o_led_update    (o_led_update),
        .o_motor_on      (o_motor_on),
        .o_motor_update  (o_motor_update)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [7:0] digit_char(int unsigned d);
        return CH_ZERO + 8'(d);
    endfunction

    // Mostly digits, sometimes any byte
    function automatic logic [7:0] loose_digit();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return digit_char($urandom_range(0, 9));
    endfunction

    // Build one random frame, a burst of noise or a broken frame
    function automatic void plan_frame();
        int unsigned kind;
        int unsigned n;
        int unsigned id_sel;
        frame_chars.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) frame_chars.push_back(8'($urandom_range(0, 255)));
            return;
        end
        frame_chars.push_back(CH_OPEN);
        if (kind <= 3) id_sel = $urandom_range(0, 7);
        else if (kind <= 5) id_sel = CMD_MEMORY;
        else if (kind <= 7) id_sel = CMD_LED;
        else id_sel = CMD_MOTOR;
        // usually one id digit; sometimes none (stale id) or a leading extra one
        n = $urandom_range(0, 11);
        if (n == 1) frame_chars.push_back(digit_char($urandom_range(0, 7)));
        if (n != 0) frame_chars.push_back(digit_char(id_sel));
        frame_chars.push_back(CH_COMMA);
        if (kind >= 4 && kind <= 5) begin
            n = $urandom_range(0, 11);
            frame_chars.push_back(n == 0 ? CH_BLANK : loose_digit());
            frame_chars.push_back($urandom_range(0, 9) == 0 ?
                                  8'($urandom_range(0, 255)) : CH_COMMA);
            frame_chars.push_back($urandom_range(0, 5) == 0 ?
                                  loose_digit() : digit_char($urandom_range(1, 5)));
            frame_chars.push_back(CH_COMMA);
        end else if (kind >= 6 && kind <= 7) begin
            n = $urandom_range(0, 3);
            repeat (n) frame_chars.push_back(loose_digit());
            frame_chars.push_back(CH_COMMA);
        end else if (kind >= 8) begin
            n = $urandom_range(0, 2);
            repeat (n) frame_chars.push_back(digit_char($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0) frame_chars.push_back(8'($urandom_range(0, 255)));
            frame_chars.push_back(CH_COMMA);
        end
        frame_chars.push_back($urandom_range(0, 15) == 0 ?
                              8'($urandom_range(0, 255)) : CH_CLOSE);
        // corrupt one character of some frames
        if ($urandom_range(0, 9) == 0) begin
            frame_chars[$urandom_range(0, frame_chars.size() - 1)] =
                8'($urandom_range(0, 255));
        end
    endfunction

    // Present one character after a random gap and hold it until accepted
    task automatic send_char(input logic [7:0] c, input bit guarded);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // keep the memory frame from locking the parser until the final tail
        if (guarded && tracker.needs_field_close()) c = CH_COMMA;
        i_in_valid <= 1'b1;
        i_rx_char  <= c;
        do @(posedge i_clk); while (o_in_stall);
        tracker.parse_char(c);
        if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_count() != 0);
    endtask

    // Result side: random stalls, then take and check one transaction
    initial begin
        t_result     got;
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 14);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.status        = t_status'(o_status);
            got.frame_done    = o_frame_done;
            got.active_mode   = o_active_mode;
            got.display_digit = o_display_digit;
            got.display_level = o_display_level;
            got.led_pattern   = o_led_pattern;
            got.led_update    = o_led_update;
            got.motor_on      = o_motor_on;
            got.motor_update  = o_motor_update;
            tracker.match_result(got);
            if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
        end
    end

    // Main sequence
    initial begin
        tracker     = new();
        cycle_count = 0;
        random_sent = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_char   <= '0;
        i_out_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme bytes, blank digit, LED overflow digits, motor,
        // bad command, stale command id
        directed_chars = {8'h00, 8'hFF,
                          CH_OPEN, digit_char(3), CH_COMMA, CH_BLANK, CH_COMMA,
                          CH_ONE, CH_COMMA, CH_CLOSE,
                          CH_OPEN, digit_char(6), CH_COMMA, CH_NINE, CH_NINE, CH_NINE,
                          CH_COMMA, CH_CLOSE,
                          CH_OPEN, CH_SEVEN, CH_COMMA, CH_ONE, CH_COMMA, CH_CLOSE,
                          CH_OPEN, CH_BLANK,
                          CH_OPEN, CH_COMMA, CH_CLOSE};
        foreach (directed_chars[i]) send_char(directed_chars[i], 1'b1);
        wait_drained();

        // Random frames, noise and broken frames
        while (random_sent < RANDOM_CHARS) begin
            plan_frame();
            foreach (frame_chars[i]) send_char(frame_chars[i], 1'b1);
            random_sent += frame_chars.size();
            if ($urandom_range(0, 59) == 0) wait_drained();
        end

        // Tail: overrun a memory frame so the field index saturates
        directed_chars = {CH_OPEN, digit_char(3), CH_COMMA, CH_FIVE, CH_COMMA, CH_ONE,
                          CH_BLANK, 8'h00, 8'hFF, CH_CLOSE, CH_OPEN, CH_COMMA};
        foreach (directed_chars[i]) send_char(directed_chars[i], 1'b0);
        i_in_valid <= 1'b0;

        // Drain and settle
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending_count() != 0) begin
            tracker.errors++;
            $display("ERROR: %0d results never arrived", tracker.pending_count());
        end
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/fcp_pkg.sv
hw/rtl/fcp_in_reg.sv
hw/rtl/fcp_parser.sv
hw/rtl/framed_command_parser_unit.sv
hw/rtl/fcp_checker.sv
verif/framed_command_parser_unit_tb.sv
